### hdl/tcce_pkg.sv
package tcce_pkg;

    // Grid size and field widths
    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;
    localparam int GLYPH_W     = 7;
    localparam int COLOUR_W    = 16;
    localparam int CODE_W      = 8;
    localparam int ROW_DEPTH   = 1 << ROW_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Glyph and colour constants
    localparam logic [GLYPH_W-1:0]  BLOCK_GLYPH  = 7'd127;
    localparam logic [GLYPH_W-1:0]  ZERO_GLYPH   = 7'd48;
    localparam logic [COLOUR_W-1:0] BLACK        = 16'h0000;
    localparam logic [COLOUR_W-1:0] TEXT_RESET   = 16'hFFFF;
    localparam logic [COLOUR_W-1:0] INSERT_RESET = 16'hF800;
    localparam logic [COLOUR_W-1:0] NORMAL_RESET = 16'h001F;

    // Character codes
    localparam logic [CODE_W-1:0] CODE_TAB        = 8'd9;
    localparam logic [CODE_W-1:0] CODE_NEWLINE    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE  = 8'd127;
    localparam logic [CODE_W-1:0] CODE_NUL        = 8'd0;
    localparam logic [CODE_W-1:0] CODE_INSERT_CUR = 8'hFF;
    localparam logic [CODE_W-1:0] CODE_NORMAL_CUR = 8'hFE;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT   = 2'd0,
        CFG_INSERT = 2'd1,
        CFG_NORMAL = 2'd2
    } tcce_cfg_idx_t;

    // Operations handed from front to back
    typedef enum logic [2:0] {
        OP_GLYPH = 3'd0,
        OP_BS    = 3'd1,
        OP_NL    = 3'd2,
        OP_TAB   = 3'd3,
        OP_BLOCK = 3'd4
    } tcce_op_code_t;

    typedef struct packed {
        tcce_op_code_t         op;
        logic [GLYPH_W-1:0]    g0;
        logic [GLYPH_W-1:0]    g1;
        logic                  two;
        logic [COLOUR_W-1:0]   colour;
    } tcce_op_t;

    typedef struct packed {
        logic                  kind;
        logic [GLYPH_W-1:0]    glyph;
        logic [COL_W-1:0]      column;
        logic [ROW_W-1:0]      row;
        logic [COLOUR_W-1:0]   colour;
        logic                  last;
    } tcce_result_t;

endpackage

### hdl/text_console_cursor_engine.sv
// Channel  | Dir | Handshake                     | Payload
// s        | in  | s_tvalid / s_tready           | s_tdata: char_code
// m        | out | m_tvalid / m_tready           | m_tdata, m_tuser (kind), m_tlast
// cfg      | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One result per cycle while m_tready keeps the output free: a printable item that wraps off
// the last row adds a page clear, a two-digit control code gives one result per digit, and a
// backspace to the row above first reads the row end table; the single output register of the
// back end sets this rate. Tab gives no result, newline a clear only off the last row; NUL is dropped at the input.
// A four-item queue lets input be taken while the back end stalls on m_tready.
// Reset clears cursor, queue and the row end valid bits at once; no sweep.
module text_console_cursor_engine
    import tcce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] char_code
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,    // [6:0] glyph, [13:7] column, [19:14] row,
                                              // [35:20] colour, [39:36] zero
    output logic                  m_tuser,    // [0] kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COLOUR_W-1:0]   cfg_data
);

    logic          q_full;
    logic          push;
    tcce_op_t      push_data;
    logic          head_valid;
    tcce_op_t      head_data;
    logic          pop;
    tcce_result_t  out_data;

    tcce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    tcce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    tcce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    // Pack result fields onto the stream
    assign m_tdata = {4'b0000, out_data.colour, out_data.row, out_data.column, out_data.glyph};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule

### hdl/tcce_front.sv
module tcce_front
    import tcce_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [CODE_W-1:0]       s_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [COLOUR_W-1:0]     cfg_data,
    input  logic                    q_full,
    output logic                    push,
    output tcce_op_t                push_data
);

    logic [COLOUR_W-1:0] text_colour_reg;
    logic [COLOUR_W-1:0] insert_colour_reg;
    logic [COLOUR_W-1:0] normal_colour_reg;
    logic [4:0]          code5;
    logic [1:0]          tens;
    logic [4:0]          ones;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    // Hold colour registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_colour_reg   <= TEXT_RESET;
            insert_colour_reg <= INSERT_RESET;
            normal_colour_reg <= NORMAL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TEXT:   text_colour_reg   <= cfg_data;
                CFG_INSERT: insert_colour_reg <= cfg_data;
                CFG_NORMAL: normal_colour_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Split a control code into decimal digits
    assign code5 = s_tdata[4:0];
    always_comb
    begin
        if (code5 >= 5'd30)
            tens = 2'd3;
        else if (code5 >= 5'd20)
            tens = 2'd2;
        else if (code5 >= 5'd10)
            tens = 2'd1;
        else
            tens = 2'd0;
        ones = code5 - ({3'b000, tens} * 5'd10);
    end

    // Classify the item into one back-end operation
    always_comb
    begin
        push_data.op     = OP_BLOCK;
        push_data.g0     = s_tdata[GLYPH_W-1:0];
        push_data.g1     = ZERO_GLYPH + {2'b00, ones};
        push_data.two    = 1'b0;
        push_data.colour = text_colour_reg;
        case (s_tdata) inside
            CODE_BACKSPACE:
            begin
                push_data.op     = OP_BS;
                push_data.colour = BLACK;
            end
            [8'd32:8'd126]:
                push_data.op = OP_GLYPH;
            CODE_NEWLINE:
                push_data.op = OP_NL;
            CODE_TAB:
                push_data.op = OP_TAB;
            [8'd1:8'd31]:
            begin
                push_data.op  = OP_GLYPH;
                push_data.two = (tens != 2'd0);
                push_data.g0  = (tens != 2'd0) ? (ZERO_GLYPH + {5'b00000, tens})
                                               : (ZERO_GLYPH + {2'b00, ones});
            end
            CODE_INSERT_CUR:
                push_data.colour = insert_colour_reg;
            CODE_NORMAL_CUR:
                push_data.colour = normal_colour_reg;
            default:
                push_data.op = OP_BLOCK;
        endcase
    end

    // Drop NUL: it causes no result
    assign push = s_tvalid && !q_full && (s_tdata != CODE_NUL);

endmodule

### hdl/tcce_queue.sv
module tcce_queue
    import tcce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tcce_op_t  push_data,
    output logic      full,
    output logic      head_valid,
    output tcce_op_t  head_data,
    input  logic      pop
);

    tcce_op_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_pop;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if ((push && !full) && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!(push && !full) && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### hdl/tcce_back.sv
module tcce_back
    import tcce_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  tcce_op_t      head_data,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output tcce_result_t  out_data
);

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_CLR  = 3'b010,
        ST_BSRD = 3'b100
    } tcce_state_t;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    tcce_state_t         state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                dig_reg, dig_next;
    logic                out_valid_reg;
    tcce_result_t        out_reg;

    logic [COL_W-1:0]    end_mem [ROW_DEPTH];
    logic                end_ok_reg [ROW_DEPTH];
    logic [COL_W-1:0]    rd_data_reg;
    logic                rd_ok_reg;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;

    logic                slot_free;
    logic                emit;
    tcce_result_t        res;
    logic                wrap;
    logic                more;
    logic [COL_W:0]      tab_col;
    logic [COL_W-1:0]    up_col;

    assign slot_free = !out_valid_reg || out_ready;
    assign wrap      = (col_reg == LAST_COL);
    assign more      = head_data.two && !dig_reg;
    assign tab_col   = {({1'b0, col_reg[COL_W-1:3]} + (COL_W-2)'(1)), 3'b000};
    assign rd_addr   = row_reg - 1'b1;
    assign up_col    = !rd_ok_reg ? '0 : ((rd_data_reg > LAST_COL) ? LAST_COL : rd_data_reg);

    // Carry out the head operation, one result per cycle while the output slot is free
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        dig_next   = dig_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        wr_en      = 1'b0;
        res.kind   = 1'b0;
        res.glyph  = BLOCK_GLYPH;
        res.column = col_reg;
        res.row    = row_reg;
        res.colour = head_data.colour;
        res.last   = 1'b1;
        case (state_reg)
            ST_RUN:
            begin
                if (head_valid)
                begin
                    case (head_data.op)
                        OP_GLYPH:
                        begin
                            if (slot_free)
                            begin
                                emit      = 1'b1;
                                res.glyph = dig_reg ? head_data.g1 : head_data.g0;
                                col_next  = wrap ? '0 : col_reg + 1'b1;
                                row_next  = wrap ? row_reg + 1'b1 : row_reg;
                                if (wrap && (row_reg == LAST_ROW))
                                begin
                                    res.last   = 1'b0;
                                    col_next   = '0;
                                    row_next   = '0;
                                    state_next = ST_CLR;
                                end
                                else if (more)
                                begin
                                    res.last = 1'b0;
                                    dig_next = 1'b1;
                                end
                                else
                                begin
                                    pop      = 1'b1;
                                    dig_next = 1'b0;
                                end
                            end
                        end
                        OP_BS:
                        begin
                            if (col_reg != '0)
                            begin
                                if (slot_free)
                                begin
                                    emit       = 1'b1;
                                    pop        = 1'b1;
                                    col_next   = col_reg - 1'b1;
                                    res.column = col_reg - 1'b1;
                                end
                            end
                            else if (row_reg == '0)
                            begin
                                if (slot_free)
                                begin
                                    emit = 1'b1;
                                    pop  = 1'b1;
                                end
                            end
                            else
                                state_next = ST_BSRD;
                        end
                        OP_NL:
                        begin
                            if ((row_reg != LAST_ROW) || slot_free)
                            begin
                                wr_en    = 1'b1;
                                pop      = 1'b1;
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                                if (row_reg == LAST_ROW)
                                begin
                                    emit       = 1'b1;
                                    res.kind   = 1'b1;
                                    res.column = '0;
                                    res.row    = '0;
                                    res.colour = BLACK;
                                    row_next   = '0;
                                end
                            end
                        end
                        OP_TAB:
                        begin
                            pop      = 1'b1;
                            col_next = (tab_col >= (COL_W+1)'(COLUMNS)) ? '0
                                                                       : tab_col[COL_W-1:0];
                        end
                        OP_BLOCK:
                        begin
                            if (slot_free)
                            begin
                                emit = 1'b1;
                                pop  = 1'b1;
                            end
                        end
                        default:
                            pop = 1'b1;
                    endcase
                end
            end
            ST_CLR:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    res.kind   = 1'b1;
                    res.column = '0;
                    res.row    = '0;
                    res.colour = BLACK;
                    res.last   = !more;
                    state_next = ST_RUN;
                    if (more)
                        dig_next = 1'b1;
                    else
                    begin
                        pop      = 1'b1;
                        dig_next = 1'b0;
                    end
                end
            end
            ST_BSRD:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    pop        = 1'b1;
                    col_next   = up_col;
                    row_next   = rd_addr;
                    res.column = up_col;
                    res.row    = rd_addr;
                    state_next = ST_RUN;
                end
            end
            default:
                state_next = ST_RUN;
        endcase
    end

    // Hold cursor and sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            col_reg   <= '0;
            row_reg   <= '0;
            dig_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            dig_reg   <= dig_next;
        end
    end

    // Row end table: write on newline, read the row above
    always_ff @(posedge clk)
    begin
        if (wr_en)
            end_mem[row_reg] <= col_reg;
        rd_data_reg <= end_mem[rd_addr];
    end

    // Mark written rows; unwritten rows read as column zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROW_DEPTH; i++)
                end_ok_reg[i] <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                end_ok_reg[row_reg] <= 1'b1;
            rd_ok_reg <= end_ok_reg[rd_addr];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A pending clear always follows a reset of the cursor to the origin
    a_clr_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> (col_reg == '0 && row_reg == '0))
        else $error("clear pending with cursor away from origin");

    // Backspace read only starts from column zero below the top row
    a_bsrd_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BSRD) |-> (col_reg == '0 && row_reg != '0))
        else $error("row above read from wrong cursor position");

    // A clear result carries the fixed origin payload
    a_clr_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind) |-> (out_reg.glyph == BLOCK_GLYPH &&
        out_reg.column == '0 && out_reg.row == '0 && out_reg.colour == BLACK))
        else $error("clear result with bad payload");

    // Once the clear leaves, sequencing returns to the run state
    a_clr_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR && slot_free) |=> (state_reg == ST_RUN))
        else $error("clear did not complete");

    // Cursor stays on the grid
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (col_reg <= LAST_COL && row_reg <= LAST_ROW))
        else $error("cursor off the grid");

endmodule

### tb/sv/text_console_cursor_engine_tb.sv
module text_console_cursor_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    localparam int PRINT_LO   = 32;
    localparam int PRINT_HI   = 126;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_TAIL = 16;
    localparam int CYCLE_CAP  = 400000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TEXT;
    logic [COLOUR_W-1:0]  cfg_data = '0;

    // Predicted cursor state and colour registers
    int                   cur_col;
    int                   cur_row;
    logic [COL_W-1:0]     row_end [ROWS];
    logic [COLOUR_W-1:0]  text_col;
    logic [COLOUR_W-1:0]  ins_colour_exp;
    logic [COLOUR_W-1:0]  nrm_colour_exp;

    tcce_result_t         pending_draws[$];
    int                   mismatch_count = 0;
    int                   draw_count = 0;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_start = 1'b0;
    int                   hold_left = 0;

    text_console_cursor_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("text_console_cursor_engine: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("ERROR draw %0d: %s", draw_count, msg);
    endtask

    // ---------------------------------------------------------------
    // Cursor predictor
    // ---------------------------------------------------------------
    function automatic void push_draw(input logic kind, input logic [GLYPH_W-1:0] glyph,
                                      input int col, input int row,
                                      input logic [COLOUR_W-1:0] colour);
        tcce_result_t d;
        d.kind   = kind;
        d.glyph  = glyph;
        d.column = COL_W'(col);
        d.row    = ROW_W'(row);
        d.colour = colour;
        d.last   = 1'b0;
        pending_draws.push_back(d);
    endfunction

    function automatic void clear_page();
        push_draw(1'b1, BLOCK_GLYPH, 0, 0, BLACK);
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic void print_glyph(input logic [GLYPH_W-1:0] g);
        push_draw(1'b0, g, cur_col, cur_row, text_col);
        cur_col++;
        if (cur_col >= COLUMNS)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS)
            clear_page();
    endfunction

    function automatic void advance_cursor(input logic [CODE_W-1:0] code);
        int                  before_n;
        int                  next_tab;
        logic [COLOUR_W-1:0] colour;
        before_n = pending_draws.size();
        if (code >= PRINT_LO && code <= PRINT_HI)
            print_glyph(GLYPH_W'(code));
        else if (code == CODE_BACKSPACE)
        begin
            if (cur_col == 0)
            begin
                // step up to the end column remembered for the row above
                if (cur_row != 0)
                begin
                    cur_row--;
                    cur_col = row_end[cur_row];
                end
            end
            else
                cur_col--;
            push_draw(1'b0, BLOCK_GLYPH, cur_col, cur_row, BLACK);
        end
        else if (code == CODE_NEWLINE)
        begin
            row_end[cur_row] = COL_W'(cur_col);
            cur_row++;
            cur_col = 0;
            if (cur_row >= ROWS)
                clear_page();
        end
        else if (code == CODE_TAB)
        begin
            next_tab = (cur_col / 8 + 1) * 8;
            cur_col  = (next_tab >= COLUMNS) ? 0 : next_tab;
        end
        else if (code < PRINT_LO)
        begin
            // other control codes print their decimal value
            if (code >= 10)
                print_glyph(ZERO_GLYPH + GLYPH_W'(code / 10));
            if (code != CODE_NUL)
                print_glyph(ZERO_GLYPH + GLYPH_W'(code % 10));
        end
        else
        begin
            colour = text_col;
            if (code == CODE_INSERT_CUR)
                colour = ins_colour_exp;
            else if (code == CODE_NORMAL_CUR)
                colour = nrm_colour_exp;
            push_draw(1'b0, BLOCK_GLYPH, cur_col, cur_row, colour);
        end
        if (pending_draws.size() > before_n)
            pending_draws[pending_draws.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Output side: ready pattern and result check
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left  = LONG_HOLD;
            hold_start = 1'b0;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        tcce_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_draws.size() == 0)
                report_mismatch($sformatf("unexpected draw tdata=%h tuser=%b", m_tdata, m_tuser));
            else
            begin
                want = pending_draws.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("kind want %0d got %0d", want.kind, m_tuser));
                if (m_tdata[6:0] !== want.glyph)
                    report_mismatch($sformatf("glyph want %0d got %0d",
                                              want.glyph, m_tdata[6:0]));
                if (m_tdata[13:7] !== want.column)
                    report_mismatch($sformatf("column want %0d got %0d",
                                              want.column, m_tdata[13:7]));
                if (m_tdata[19:14] !== want.row)
                    report_mismatch($sformatf("row want %0d got %0d",
                                              want.row, m_tdata[19:14]));
                if (m_tdata[35:20] !== want.colour)
                    report_mismatch($sformatf("colour want %h got %h",
                                              want.colour, m_tdata[35:20]));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last want %0d got %0d", want.last, m_tlast));
            end
            draw_count++;
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_char(input byte code);
        // idle a random stretch before the item
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do
            @(posedge clk);
        while (!s_tready);
        advance_cursor(code);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        // let items with no draw leave the pipeline
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic cfg_beat(input tcce_cfg_idx_t idx, input logic [COLOUR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_colours(input logic [COLOUR_W-1:0] t_col,
                                 input logic [COLOUR_W-1:0] i_col,
                                 input logic [COLOUR_W-1:0] n_col);
        wait_drained();
        cfg_beat(CFG_TEXT, t_col);
        cfg_beat(CFG_INSERT, i_col);
        cfg_beat(CFG_NORMAL, n_col);
        cfg_valid <= 1'b0;
        text_col       = t_col;
        ins_colour_exp = i_col;
        nrm_colour_exp = n_col;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        byte codes[] = '{CODE_BACKSPACE, 8'd32, 8'd126, 8'd65, CODE_INSERT_CUR,
                         CODE_NORMAL_CUR, 8'h80, 8'hFD, CODE_NUL, 8'd1, 8'd8, 8'd11,
                         8'd19, 8'd31, CODE_NEWLINE, CODE_BACKSPACE, CODE_TAB, CODE_TAB,
                         CODE_BACKSPACE, 8'd127, 8'h7E};
        foreach (codes[i])
            send_char(codes[i]);
    endtask

    // Backspace across rows back to the remembered end column
    task automatic test_row_recall();
        send_char(CODE_NEWLINE);
        repeat (15) send_char(CODE_TAB);
        repeat (7) send_char(byte'($urandom_range(PRINT_LO, PRINT_HI)));
        send_char(CODE_NEWLINE);
        send_char(CODE_BACKSPACE);
        send_char(CODE_BACKSPACE);
        // tab from the last tab stop wraps to column zero
        send_char(CODE_NEWLINE);
        repeat (16) send_char(CODE_TAB);
        send_char(CODE_BACKSPACE);
    endtask

    task automatic test_screen_overflow();
        // newline off the bottom clears the page
        while (cur_row != 0 || cur_col != 0)
            send_char(CODE_NEWLINE);
        // two-digit code whose first digit wraps off the last row and clears the page
        repeat (ROWS - 1) send_char(CODE_NEWLINE);
        repeat (15) send_char(CODE_TAB);
        repeat (7) send_char(byte'($urandom_range(PRINT_LO, PRINT_HI)));
        send_char(8'd25);
        send_char(CODE_BACKSPACE);
        send_char(CODE_BACKSPACE);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_start = 1'b1;
        repeat (30)
        begin
            if ($urandom_range(3) == 0)
                send_char(byte'($urandom_range(11, 31)));
            else
                send_char(byte'($urandom_range(PRINT_LO, PRINT_HI)));
        end
        // pause until every draw is out, then resume
        wait_drained();
        repeat (10) send_char(byte'($urandom_range(PRINT_LO, PRINT_HI)));
    endtask

    task automatic test_random_text(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // a word followed by a space
                len = $urandom_range(1, 8);
                repeat (len) send_char(byte'($urandom_range(PRINT_LO + 1, PRINT_HI)));
                send_char(8'd32);
                sent += len + 1;
            end
            else if (pick < 67)
            begin
                send_char(CODE_NEWLINE);
                sent++;
            end
            else if (pick < 75)
            begin
                len = $urandom_range(1, 16);
                repeat (len) send_char(CODE_TAB);
                sent += len;
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_char(CODE_BACKSPACE);
                sent += len;
            end
            else if (pick < 92)
            begin
                send_char(byte'($urandom_range(0, 31)));
                sent++;
            end
            else
            begin
                if ($urandom_range(1))
                    send_char($urandom_range(1) ? CODE_INSERT_CUR : CODE_NORMAL_CUR);
                else
                    send_char(byte'($urandom_range(128, 255)));
                sent++;
            end
        end
    endtask

    initial
    begin
        cur_col    = 0;
        cur_row    = 0;
        foreach (row_end[i])
            row_end[i] = '0;
        text_col       = TEXT_RESET;
        ins_colour_exp = INSERT_RESET;
        nrm_colour_exp = NORMAL_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_directed();
        test_row_recall();
        set_idling(25, 25);
        test_screen_overflow();
        wait_drained();
        test_backpressure();

        // random text under each idling pattern and colour setting
        write_colours(16'h0000, 16'h0000, 16'h0000);
        set_idling(0, 0);
        test_random_text(15);
        write_colours(16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_idling(88, 0);
        test_random_text(15);
        write_colours(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
        set_idling(0, 88);
        test_random_text(15);
        write_colours(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
        set_idling(25, 25);
        test_random_text(15);

        wait_drained();
        if (mismatch_count == 0)
            $display("text_console_cursor_engine: match");
        else
            $display("text_console_cursor_engine: mismatch");
        $finish;
    end

endmodule
